>>> hdl/pcoe_pkg.sv
// Shared types and constants for the piecewise cubic offset evaluator.
package pcoe_pkg;

  localparam int unsigned SEGMENTS_DEF = 16;

  localparam int unsigned SEG_IDX_W = 4;
  localparam int unsigned POS_W     = 32;
  localparam int unsigned COEF_W    = 48;
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned RES_W     = 32;

  localparam int unsigned IN_DATA_W  = 264;
  localparam int unsigned IN_USER_W  = 1;
  localparam int unsigned OUT_DATA_W = 40;
  localparam int unsigned OUT_USER_W = 2;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_QUERY = 1'b1
  } req_e;

  typedef struct packed {
    req_e                     req;
    logic [SEG_IDX_W-1:0]     seg_index;
    logic signed [COEF_W-1:0] coef_a;
    logic signed [COEF_W-1:0] coef_b;
    logic signed [COEF_W-1:0] coef_c;
    logic signed [COEF_W-1:0] coef_d;
    logic [POS_W-1:0]         query_pos;
  } item_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] a;
    logic signed [COEF_W-1:0] b;
    logic signed [COEF_W-1:0] c;
    logic signed [COEF_W-1:0] d;
  } coefs_t;

  typedef struct packed {
    logic                     found;
    logic [SEG_IDX_W-1:0]     used;
    logic                     sat;
    logic [POS_W-1:0]         ds;
    logic signed [COEF_W-1:0] acc;
    logic signed [COEF_W-1:0] coef_c;
    logic signed [COEF_W-1:0] coef_b;
    logic signed [COEF_W-1:0] coef_a;
  } eval_t;

endpackage

>>> hdl/pcoe_search.sv
// Segment start table with a registered maximum-search tree over all entries.
module pcoe_search #(
  parameter int unsigned SEGMENTS = pcoe_pkg::SEGMENTS_DEF,
  localparam int unsigned LVL = $clog2(SEGMENTS),
  localparam int unsigned IW  = (LVL > 0) ? LVL : 1,
  localparam int unsigned P   = 1 << LVL
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         vld_i,
  input  pcoe_pkg::item_t              item_i,
  input  logic [pcoe_pkg::POS_W-1:0]   start_i,
  input  logic [pcoe_pkg::CNT_W-1:0]   count_i,
  output logic                         vld_o,
  output pcoe_pkg::item_t              item_o,
  output logic                         found_o,
  output logic [IW-1:0]                idx_o,
  output logic [pcoe_pkg::POS_W-1:0]   start_o
);

  typedef struct packed {
    logic                       found;
    logic [pcoe_pkg::POS_W-1:0] start;
    logic [IW-1:0]              idx;
  } node_t;

  logic [pcoe_pkg::POS_W-1:0] start_q [SEGMENTS];
  node_t                      nodes_q [2*P-1];
  logic [LVL:0]               vld_q;
  pcoe_pkg::item_t            pipe_q  [LVL+1];

  // On equal starts the left child, which holds the lower index, is kept.
  function automatic node_t pick(node_t l, node_t r);
    if (r.found && (!l.found || r.start > l.start)) begin
      return r;
    end
    return l;
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i && vld_i && item_i.req == pcoe_pkg::REQ_WRITE &&
        32'(item_i.seg_index) < 32'(SEGMENTS)) begin
      start_q[IW'(item_i.seg_index)] <= start_i;
    end
  end

  for (genvar g = 0; g < P; g++) begin : g_leaf
    if (g < SEGMENTS) begin : g_used
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          nodes_q[P-1+g].found <= (32'(g) < 32'(count_i)) &&
                                  (start_q[g] <= item_i.query_pos);
          nodes_q[P-1+g].start <= start_q[g];
          nodes_q[P-1+g].idx   <= IW'(g);
        end
      end
    end else begin : g_pad
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          nodes_q[P-1+g] <= '0;
        end
      end
    end
  end

  for (genvar g = 0; g < P - 1; g++) begin : g_node
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nodes_q[g] <= pick(nodes_q[2*g+1], nodes_q[2*g+2]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q[0] <= vld_i;
      for (int k = 1; k <= LVL; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pipe_q[0] <= item_i;
      for (int k = 1; k <= LVL; k++) begin
        pipe_q[k] <= pipe_q[k-1];
      end
    end
  end

  assign vld_o   = vld_q[LVL];
  assign item_o  = pipe_q[LVL];
  assign found_o = nodes_q[0].found;
  assign idx_o   = nodes_q[0].idx;
  assign start_o = nodes_q[0].start;

endmodule

>>> hdl/pcoe_horner_step.sv
// One three-stage Horner step: multiply, scale and clamp, add and saturate.
module pcoe_horner_step (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            vld_i,
  input  pcoe_pkg::eval_t data_i,
  output logic            vld_o,
  output pcoe_pkg::eval_t data_o
);

  localparam logic signed [65:0] LIM_POS = 66'sh1_0000_0000_0000;
  localparam logic signed [65:0] LIM_NEG = -LIM_POS;
  localparam logic signed [50:0] SAT_MAX = 51'sh7FFF_FFFF_FFFF;
  localparam logic signed [50:0] SAT_MIN = -SAT_MAX - 51'sd1;

  logic                s1_vld_q, s2_vld_q, s3_vld_q;
  pcoe_pkg::eval_t     s1_data_q, s2_data_q, s3_data_q, s3_data_d;
  logic signed [16:0]  hi_s, lo_s;
  logic signed [64:0]  p_hi_d, p_lo_d, p_hi_q, p_lo_q;
  logic signed [65:0]  t_d;
  logic signed [49:0]  tc_d, tc_q;
  logic signed [50:0]  sum_d;

  always_comb begin
    hi_s   = $signed({1'b0, data_i.ds[31:16]});
    lo_s   = $signed({1'b0, data_i.ds[15:0]});
    p_hi_d = 65'(data_i.acc) * 65'(hi_s);
    p_lo_d = 65'(data_i.acc) * 65'(lo_s);
  end

  always_comb begin
    t_d = 66'(p_hi_q) + 66'(p_lo_q >>> 16);
    if (t_d > LIM_POS) begin
      tc_d = 50'(LIM_POS);
    end else if (t_d < LIM_NEG) begin
      tc_d = 50'(LIM_NEG);
    end else begin
      tc_d = 50'(t_d);
    end
  end

  always_comb begin
    sum_d            = 51'(tc_q) + 51'(s2_data_q.coef_c);
    s3_data_d        = s2_data_q;
    s3_data_d.coef_c = s2_data_q.coef_b;
    s3_data_d.coef_b = s2_data_q.coef_a;
    if (sum_d > SAT_MAX) begin
      s3_data_d.acc = 48'(SAT_MAX);
      s3_data_d.sat = 1'b1;
    end else if (sum_d < SAT_MIN) begin
      s3_data_d.acc = 48'(SAT_MIN);
      s3_data_d.sat = 1'b1;
    end else begin
      s3_data_d.acc = 48'(sum_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else if (en_i) begin
      s1_vld_q <= vld_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_data_q <= data_i;
      p_hi_q    <= p_hi_d;
      p_lo_q    <= p_lo_d;
      s2_data_q <= s1_data_q;
      tc_q      <= tc_d;
      s3_data_q <= s3_data_d;
    end
  end

  assign vld_o  = s3_vld_q;
  assign data_o = s3_data_q;

endmodule

>>> hdl/piecewise_cubic_offset_eval_core.sv
// Top level of the piecewise cubic offset evaluator.
//
//   port group  direction  contents
//   s_axis      in         segment writes and position queries, one per beat
//   m_axis      out        one result beat for every input beat
//   cfg         in         segment_count register write
//
// Every beat, write or query, passes a fully pipelined path: one compare stage,
// clog2(SEGMENTS) search-tree stages, one coefficient read stage, three Horner
// steps of three stages each and the output register.
// A new beat can be taken in every cycle. When the output register holds a
// beat that is not taken, the whole pipeline holds and s_axis_tready falls.
// Reset clears the valid bits and segment_count; table contents are undefined
// until written.
module piecewise_cubic_offset_eval_core #(
  parameter int unsigned SEGMENTS = pcoe_pkg::SEGMENTS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // seg_index, seg_start, coef_a, coef_b, coef_c, coef_d, query_pos, zero fill
  input  logic [pcoe_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // req_type
  input  logic [pcoe_pkg::IN_USER_W-1:0]      s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // offset_value, segment_used, zero fill
  output logic [pcoe_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // segment_found, saturated
  output logic [pcoe_pkg::OUT_USER_W-1:0]     m_axis_tuser,
  input  logic                                cfg_we_i,
  input  logic [pcoe_pkg::CNT_W-1:0]          cfg_wdata_i
);

  localparam int unsigned LVL = $clog2(SEGMENTS);
  localparam int unsigned IW  = (LVL > 0) ? LVL : 1;

  logic                              en;
  pcoe_pkg::item_t                   in_item;
  logic [pcoe_pkg::POS_W-1:0]        in_start;
  logic [pcoe_pkg::CNT_W-1:0]        seg_count_q;

  logic                              srch_vld;
  pcoe_pkg::item_t                   srch_item;
  logic                              srch_found;
  logic [IW-1:0]                     srch_idx;
  logic [pcoe_pkg::POS_W-1:0]        srch_start;

  pcoe_pkg::coefs_t                  coef_mem [SEGMENTS];
  pcoe_pkg::coefs_t                  rd_coef_q;
  logic                              rd_vld_q;
  pcoe_pkg::item_t                   rd_item_q;
  logic                              rd_found_q;
  logic [IW-1:0]                     rd_idx_q;
  logic [pcoe_pkg::POS_W-1:0]        rd_ds_q;

  pcoe_pkg::eval_t                   st_data [4];
  logic [3:0]                        st_vld;

  logic                              m_vld_q;
  logic [pcoe_pkg::RES_W-1:0]        m_offset_q;
  logic [pcoe_pkg::SEG_IDX_W-1:0]    m_used_q;
  logic                              m_found_q;
  logic                              m_sat_q;

  assign en            = !m_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  always_comb begin
    in_item.req       = pcoe_pkg::req_e'(s_axis_tuser[0]);
    in_item.seg_index = s_axis_tdata[3:0];
    in_item.coef_a    = s_axis_tdata[83:36];
    in_item.coef_b    = s_axis_tdata[131:84];
    in_item.coef_c    = s_axis_tdata[179:132];
    in_item.coef_d    = s_axis_tdata[227:180];
    in_item.query_pos = s_axis_tdata[259:228];
    in_start          = s_axis_tdata[35:4];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_count_q <= '0;
    end else if (cfg_we_i) begin
      seg_count_q <= cfg_wdata_i;
    end
  end

  pcoe_search #(
    .SEGMENTS(SEGMENTS)
  ) u_search (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s_axis_tvalid),
    .item_i (in_item),
    .start_i(in_start),
    .count_i(seg_count_q),
    .vld_o  (srch_vld),
    .item_o (srch_item),
    .found_o(srch_found),
    .idx_o  (srch_idx),
    .start_o(srch_start)
  );

  // Coefficients are written at the same stage as they are read, so every
  // query sees exactly the writes that came before it.
  always_ff @(posedge clk_i) begin
    if (en) begin
      if (srch_vld && srch_item.req == pcoe_pkg::REQ_WRITE &&
          32'(srch_item.seg_index) < 32'(SEGMENTS)) begin
        coef_mem[IW'(srch_item.seg_index)] <= '{a: srch_item.coef_a,
                                                b: srch_item.coef_b,
                                                c: srch_item.coef_c,
                                                d: srch_item.coef_d};
      end
      rd_coef_q  <= coef_mem[srch_idx];
      rd_item_q  <= srch_item;
      rd_found_q <= srch_found;
      rd_idx_q   <= srch_idx;
      rd_ds_q    <= srch_item.query_pos - srch_start;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else if (en) begin
      rd_vld_q <= srch_vld;
    end
  end

  always_comb begin
    st_vld[0]         = rd_vld_q;
    st_data[0].found  = rd_found_q && rd_item_q.req == pcoe_pkg::REQ_QUERY;
    st_data[0].used   = pcoe_pkg::SEG_IDX_W'(rd_idx_q);
    st_data[0].sat    = 1'b0;
    st_data[0].ds     = rd_ds_q;
    st_data[0].acc    = rd_coef_q.d;
    st_data[0].coef_c = rd_coef_q.c;
    st_data[0].coef_b = rd_coef_q.b;
    st_data[0].coef_a = rd_coef_q.a;
  end

  for (genvar g = 0; g < 3; g++) begin : g_step
    pcoe_horner_step u_step (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .vld_i (st_vld[g]),
      .data_i(st_data[g]),
      .vld_o (st_vld[g+1]),
      .data_o(st_data[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (en) begin
      m_vld_q <= st_vld[3];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_found_q  <= st_data[3].found;
      m_sat_q    <= st_data[3].found && st_data[3].sat;
      m_used_q   <= st_data[3].found ? st_data[3].used : '0;
      m_offset_q <= st_data[3].found ? st_data[3].acc[47:16] : '0;
    end
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = {4'b0, m_used_q, m_offset_q};
  assign m_axis_tuser  = {m_sat_q, m_found_q};

`ifndef NO_ASSERTIONS
  a_miss_is_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0 && !m_axis_tuser[1])
    else $error("result without a segment carries a value or flag");

  a_hit_not_after : assert property (@(posedge clk_i) disable iff (!rst_ni)
    srch_vld && srch_found |-> srch_start <= srch_item.query_pos)
    else $error("chosen segment starts after the query position");

  a_ds_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q && rd_found_q |-> rd_ds_q <= rd_item_q.query_pos)
    else $error("segment offset exceeds the query position");
`endif

endmodule

>>> bench/tb.sv
// Self-checking testbench for the piecewise cubic offset evaluator core.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned SEGS = pcoe_pkg::SEGMENTS_DEF;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam logic signed [47:0] COEF_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] COEF_MIN = 48'sh8000_0000_0000;
  localparam logic signed [47:0] COEF_ONE = 48'sh0001_0000_0000;
  localparam logic signed [95:0] ACC_MAX = 96'sh7FFF_FFFF_FFFF;
  localparam logic signed [95:0] ACC_MIN = -ACC_MAX - 96'sd1;

  typedef struct packed {
    pcoe_pkg::req_e     req;
    logic [3:0]         fill;
    logic [31:0]        pos;
    logic signed [47:0] d;
    logic signed [47:0] c;
    logic signed [47:0] b;
    logic signed [47:0] a;
    logic [31:0]        start;
    logic [3:0]         idx;
  } seg_beat_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               found;
    logic [3:0]         used;
    logic               sat;
  } offset_res_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [pcoe_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [pcoe_pkg::IN_USER_W-1:0]  s_axis_tuser = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [pcoe_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic [pcoe_pkg::OUT_USER_W-1:0] m_axis_tuser;
  logic                            cfg_we_i = 1'b0;
  logic [pcoe_pkg::CNT_W-1:0]      cfg_wdata_i = '0;

  piecewise_cubic_offset_eval_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  logic [31:0]                start_tab [SEGS];
  logic signed [47:0]         const_tab [SEGS];
  logic signed [47:0]         lin_tab   [SEGS];
  logic signed [47:0]         quad_tab  [SEGS];
  logic signed [47:0]         cubic_tab [SEGS];
  logic [pcoe_pkg::CNT_W-1:0] seg_count_q = '0;
  logic [31:0]                gen_start [SEGS];

  seg_beat_t   pending_beats [$];
  offset_res_t expected_offsets [$];

  bit          s_taken = 1'b0;
  bit          m_taken = 1'b0;
  bit          s_busy = 1'b0;
  bit          send_idle = 1'b1;
  bit          recv_idle = 1'b1;
  int unsigned s_gap = 0;
  int unsigned r_wait = 0;
  int unsigned idle_cycles = 0;
  int unsigned beats_queued = 0;
  int unsigned results_seen = 0;
  int unsigned errors = 0;
  int unsigned n_writes = 0;
  int unsigned n_queries = 0;
  int unsigned n_hits = 0;
  int unsigned n_clipped = 0;
  int unsigned n_settings = 0;

  function automatic logic signed [47:0] horner_step(input logic signed [47:0] acc,
                                                     input logic [31:0] ds,
                                                     input logic signed [47:0] coef,
                                                     output logic clipped);
    logic signed [95:0] acc_w, ds_w, coef_w, sum;
    acc_w = acc;
    ds_w = {64'd0, ds};
    coef_w = coef;
    sum = ((acc_w * ds_w) >>> 16) + coef_w;
    clipped = 1'b0;
    if (sum > ACC_MAX) begin
      clipped = 1'b1;
      return ACC_MAX[47:0];
    end
    if (sum < ACC_MIN) begin
      clipped = 1'b1;
      return ACC_MIN[47:0];
    end
    return sum[47:0];
  endfunction

  function automatic offset_res_t offset_predict(input seg_beat_t bt);
    offset_res_t        r;
    int unsigned        lim;
    logic [3:0]         best;
    logic               hit, c0, c1, c2;
    logic [31:0]        ds;
    logic signed [47:0] acc, acc_sh;
    r = '0;
    if (bt.req == pcoe_pkg::REQ_WRITE) begin
      if (bt.idx < SEGS) begin
        start_tab[bt.idx] = bt.start;
        const_tab[bt.idx] = bt.a;
        lin_tab[bt.idx]   = bt.b;
        quad_tab[bt.idx]  = bt.c;
        cubic_tab[bt.idx] = bt.d;
      end
      return r;
    end
    lim = (32'(seg_count_q) > SEGS) ? SEGS : 32'(seg_count_q);
    hit = 1'b0;
    best = '0;
    for (int i = 0; i < lim; i++) begin
      if (start_tab[i] <= bt.pos && (!hit || start_tab[i] > start_tab[best])) begin
        best = i[3:0];
        hit = 1'b1;
      end
    end
    if (!hit) return r;
    ds = bt.pos - start_tab[best];
    acc = horner_step(cubic_tab[best], ds, quad_tab[best], c0);
    acc = horner_step(acc, ds, lin_tab[best], c1);
    acc = horner_step(acc, ds, const_tab[best], c2);
    acc_sh = acc >>> 16;
    r.value = acc_sh[31:0];
    r.found = 1'b1;
    r.used = best;
    r.sat = c0 | c1 | c2;
    return r;
  endfunction

  function automatic logic signed [47:0] rand_coef();
    logic [63:0]        r;
    logic signed [34:0] mid;
    logic signed [19:0] tiny;
    r = {$urandom, $urandom};
    mid = r[34:0];
    tiny = r[19:0];
    case ($urandom_range(0, 5))
      0, 1: return 48'(mid);
      2: return 48'(tiny);
      3: return r[47:0];
      4: return r[0] ? COEF_MAX : COEF_MIN;
      default: return 48'sd0;
    endcase
  endfunction

  task automatic push_write(input logic [3:0] idx, input logic [31:0] start,
                            input logic signed [47:0] a, b, c, d);
    seg_beat_t bt;
    bt = '0;
    bt.req = pcoe_pkg::REQ_WRITE;
    bt.idx = idx;
    bt.start = start;
    bt.a = a;
    bt.b = b;
    bt.c = c;
    bt.d = d;
    bt.pos = $urandom;
    gen_start[idx] = start;
    pending_beats.push_back(bt);
    beats_queued++;
  endtask

  task automatic push_query(input logic [31:0] pos);
    seg_beat_t bt;
    bt = '0;
    bt.req = pcoe_pkg::REQ_QUERY;
    bt.idx = 4'($urandom_range(0, 15));
    bt.start = $urandom;
    bt.a = 48'({$urandom, $urandom});
    bt.b = 48'({$urandom, $urandom});
    bt.c = 48'({$urandom, $urandom});
    bt.d = 48'({$urandom, $urandom});
    bt.pos = pos;
    pending_beats.push_back(bt);
    beats_queued++;
  endtask

  task automatic drain();
    while (results_seen < beats_queued) @(negedge clk_i);
  endtask

  task automatic set_count(input logic [pcoe_pkg::CNT_W-1:0] cnt);
    drain();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= cnt;
    seg_count_q = cnt;
    n_settings++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 10)
        $display("tb: %s mismatch on result %0d: expected %h, got %h",
                 name, results_seen, want, got);
    end
  endtask

  // Sender: one beat per pending item, with a random gap before the next one when send_idle is set.
  always @(negedge clk_i) begin
    seg_beat_t nb;
    if (rst_ni) begin
      if (s_busy && s_taken) s_busy = 1'b0;
      if (!s_busy) begin
        if (s_gap != 0) begin
          s_gap--;
        end else if (pending_beats.size() != 0) begin
          nb = pending_beats.pop_front();
          s_axis_tdata <= nb[pcoe_pkg::IN_DATA_W-1:0];
          s_axis_tuser <= nb.req;
          s_busy = 1'b1;
          s_gap = send_idle ? $urandom_range(0, 7) : 0;
        end
      end
      s_axis_tvalid <= s_busy;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (m_taken) r_wait = recv_idle ? $urandom_range(0, 7) : 0;
      else if (r_wait != 0) r_wait--;
      m_axis_tready <= (r_wait == 0);
    end
  end

  always @(posedge clk_i) begin
    seg_beat_t   ib;
    offset_res_t want, got;
    if (rst_ni) begin
      s_taken = s_axis_tvalid && s_axis_tready;
      m_taken = m_axis_tvalid && m_axis_tready;
      if (s_taken) begin
        ib = seg_beat_t'({s_axis_tuser, s_axis_tdata});
        if (ib.req == pcoe_pkg::REQ_WRITE) n_writes++;
        else n_queries++;
        expected_offsets.push_back(offset_predict(ib));
      end
      if (m_taken) begin
        got.value = m_axis_tdata[31:0];
        got.used = m_axis_tdata[35:32];
        got.found = m_axis_tuser[0];
        got.sat = m_axis_tuser[1];
        results_seen++;
        if (expected_offsets.size() == 0) begin
          errors++;
          if (errors <= 10) $display("tb: result beat %0d arrived unexpected", results_seen);
        end else begin
          want = expected_offsets.pop_front();
          if (want.found) n_hits++;
          if (want.sat) n_clipped++;
          check_field("offset_value", want.value, got.value);
          check_field("segment_found", 32'(want.found), 32'(got.found));
          check_field("segment_used", 32'(want.used), 32'(got.used));
          check_field("saturated", 32'(want.sat), 32'(got.sat));
        end
      end
      if (s_taken || m_taken) begin
        idle_cycles = 0;
      end else if (++idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: watchdog expired with %0d results outstanding",
                 beats_queued - results_seen);
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0]                start, pos;
    logic [pcoe_pkg::CNT_W-1:0] cnt;
    int unsigned                k, n;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // With no valid entries every query misses.
    push_query(32'h0000_0000);
    push_query(32'hFFFF_FFFF);
    push_write(4'd0, 32'h0000_0100, COEF_ONE, COEF_ONE >>> 1, 48'sd0, 48'sd0);
    push_write(4'd1, 32'h0001_0000, 48'sd0, 48'sd0, 48'sd0, COEF_MAX);
    push_write(4'd2, 32'h8000_0000, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
    push_write(4'd3, 32'hFFFF_FFFF, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
    push_write(4'd4, 32'h0001_0000, -48'sd1, COEF_ONE, -COEF_ONE, COEF_ONE);
    push_write(4'd5, 32'h0000_0000, -COEF_ONE, -48'sd300, -48'sd20, -48'sd1);
    for (int i = 6; i < SEGS; i++)
      push_write(i[3:0], 32'h0002_0000 + i * 32'h0001_0000, rand_coef(), rand_coef(),
                 rand_coef(), rand_coef());

    set_count(5'd5);
    push_query(32'h0000_0000);
    push_query(32'h0000_0100);
    push_query(32'h0001_0000);
    push_query(32'h0001_FFFF);
    push_query(32'hFFFF_FFFE);
    push_query(32'hFFFF_FFFF);

    set_count(5'd31);
    push_query(32'h0000_0000);
    push_query(32'h7FFF_FFFF);
    push_query(32'h0009_8000);

    for (int ph = 0; ph < 24; ph++) begin
      if (ph == 0) cnt = 5'd0;
      else if (ph == 1) cnt = 5'd16;
      else begin
        case ($urandom_range(0, 9))
          0: cnt = 5'd16;
          1: cnt = 5'($urandom_range(17, 31));
          default: cnt = 5'($urandom_range(1, 15));
        endcase
      end
      set_count(cnt);
      send_idle = ($urandom_range(0, 3) != 0);
      recv_idle = ($urandom_range(0, 3) != 0);
      n = $urandom_range(40, 80);
      repeat (n) begin
        k = $urandom_range(0, 15);
        if ($urandom_range(0, 3) == 0) begin
          case ($urandom_range(0, 3))
            0: start = $urandom;
            1: start = $urandom_range(0, 15) * 32'h0001_0000 + $urandom_range(0, 255);
            2: start = gen_start[k];
            default: start = $urandom_range(0, 32'h000F_FFFF);
          endcase
          push_write(4'($urandom_range(0, 15)), start, rand_coef(), rand_coef(),
                     rand_coef(), rand_coef());
        end else begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3: pos = gen_start[k] + $urandom_range(0, 32'h0003_FFFF);
            4: pos = gen_start[k];
            5: pos = gen_start[k] - 32'd1;
            default: pos = $urandom;
          endcase
          push_query(pos);
        end
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (expected_offsets.size() != 0) begin
      errors++;
      $display("tb: %0d expected results never arrived", expected_offsets.size());
    end
    $display("tb: %0d segment writes and %0d position queries over %0d count settings",
             n_writes, n_queries, n_settings);
    $display("tb: %0d queries hit a segment, %0d of them clipped; %0d mismatches",
             n_hits, n_clipped, errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
